@@ hw/rtl/bt_ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// bt_ffa_pkg: shared types and constants of the boundary-tag allocator
// Tag, index and configuration widths, register map and the tag write request.
// ----------------------------------------------------------------------------
package bt_ffa_pkg;

    localparam int TAG_W   = 13;
    localparam int IDX_W   = 12;
    localparam int END_W   = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_HEAP_BYTES = 1'b0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [TAG_W-1:0] data;
    } tag_wr_t;

    function automatic logic [TAG_W-1:0] make_tag(input logic [TAG_W-1:0] size,
                                                  input logic alloc);
        make_tag = {size[TAG_W-1:2], 1'b0, alloc};
    endfunction

endpackage

@@ hw/rtl/bt_ffa_tag_mem.sv @@
// ----------------------------------------------------------------------------
// bt_ffa_tag_mem: tag word storage
// One write and one registered read per cycle; writes at or past the heap end
// are dropped.
// ----------------------------------------------------------------------------
module bt_ffa_tag_mem #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                        clk,
    input  bt_ffa_pkg::tag_wr_t         wr,
    input  logic [bt_ffa_pkg::IDX_W-1:0] raddr,
    input  logic [bt_ffa_pkg::END_W-1:0] end_word,
    output logic [bt_ffa_pkg::TAG_W-1:0] rdata
);
    import bt_ffa_pkg::*;

    localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;

    logic [TAG_W-1:0] mem [HEAP_WORDS];
    logic             wr_ok;

    assign wr_ok = wr.en && (wr.addr < {1'b0, end_word});

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[AW'(wr.addr)] <= wr.data;
        end
        rdata <= mem[AW'(raddr)];
    end

endmodule

@@ hw/rtl/boundary_tag_first_fit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_core: first-fit heap allocator, tag walk
// Keeps the heap as an implicit list of header/footer tagged blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries func, req_bytes and
//   block_offset; response channel (rsp_valid/rsp_ready) carries status and
//   payload_offset, one response transaction per request transaction.
//   An allocate walks the block tags one by one from the heap start, then
//   writes the header and footer of the first fitting free block, and two
//   more tags when that block is split. A free reads the header, previous
//   footer and next header where present, then makes two tag writes; an
//   offset outside the heap goes straight to the response.
//   One request is in work at a time; req_ready is high only when idle.
//   A finished response sits in an output register; a new request is taken
//   while it waits, and the next response holds until rsp_ready frees it.
//   After reset, and after each heap_bytes write, a clearing pass writes
//   every tag word below the heap end (heap_bytes/4 words, at most 1024)
//   and forms one free block; req_ready stays low during the pass.
//   heap_bytes lives at byte address 0 of the APB port; pready is always high.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_core #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bt_ffa_pkg::PADDR_W-1:0]  paddr,
    input  logic [bt_ffa_pkg::PDATA_W-1:0]  pwdata,
    output logic [bt_ffa_pkg::PDATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            func,
    input  logic [11:0]                     req_bytes,
    input  logic [11:0]                     block_offset,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic                            status,
    output logic [11:0]                     payload_offset
);
    import bt_ffa_pkg::*;

    localparam int LIMIT_WORDS = (HEAP_WORDS < 1024) ? HEAP_WORDS : 1024;
    localparam int LIMIT_BYTES = 4 * LIMIT_WORDS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CHK = 4'd3;
    localparam logic [3:0] S_A_W1  = 4'd4;
    localparam logic [3:0] S_A_W2  = 4'd5;
    localparam logic [3:0] S_A_W3  = 4'd6;
    localparam logic [3:0] S_F_HDR = 4'd7;
    localparam logic [3:0] S_F_PRV = 4'd8;
    localparam logic [3:0] S_F_NRD = 4'd9;
    localparam logic [3:0] S_F_NXT = 4'd10;
    localparam logic [3:0] S_F_WH  = 4'd11;
    localparam logic [3:0] S_F_WF  = 4'd12;
    localparam logic [3:0] S_RESP  = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [END_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] h_reg, h_next;
    logic [IDX_W-1:0] nxt_reg, nxt_next;
    logic [TAG_W-1:0] size_reg, size_next;
    logic [TAG_W-1:0] avail_reg, avail_next;
    logic             split_reg, split_next;
    logic             res_status_reg, res_status_next;
    logic [11:0]      res_off_reg, res_off_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             status_reg, status_next;
    logic [11:0]      poff_reg, poff_next;

    tag_wr_t          wr;
    logic [IDX_W-1:0] raddr;
    logic [TAG_W-1:0] rdata;

    logic [IDX_W-1:0] end_ext;
    logic [TAG_W-1:0] t_size;
    logic             t_free;
    logic [IDX_W-1:0] t_step;
    logic [IDX_W-1:0] q_size;
    logic [IDX_W-1:0] q_avail;
    logic [TAG_W-1:0] rem_size;
    logic [IDX_W-1:0] h_plus1;
    logic [9:0]       fw;
    logic [IDX_W-1:0] fh;
    logic             cfg_wr;
    logic             cfg_hit;
    logic [TAG_W-1:0] cfg_b;
    logic [TAG_W-1:0] cfg_clamp;

    bt_ffa_tag_mem #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_tag_mem (
        .clk      (clk),
        .wr       (wr),
        .raddr    (raddr),
        .end_word (end_reg),
        .rdata    (rdata)
    );

    assign end_ext   = {1'b0, end_reg};
    assign t_size    = {rdata[TAG_W-1:2], 2'b00};
    assign t_free    = !rdata[0];
    assign t_step    = h_reg + IDX_W'(2) + {1'b0, rdata[TAG_W-1:2]};
    assign q_size    = {1'b0, size_reg[TAG_W-1:2]};
    assign q_avail   = {1'b0, avail_reg[TAG_W-1:2]};
    assign rem_size  = avail_reg - size_reg - TAG_W'(8);
    assign h_plus1   = h_reg + IDX_W'(1);
    assign fw        = block_offset[11:2];
    assign fh        = {2'b00, fw} - IDX_W'(1);

    assign cfg_hit   = (paddr[PADDR_W-1:2] == REG_HEAP_BYTES);
    assign cfg_wr    = psel && penable && pwrite && pready && cfg_hit;
    assign cfg_b     = pwdata[TAG_W-1:0] & TAG_W'(13'h1FFC);

    always_comb
    begin
        if (cfg_b < TAG_W'(8))
        begin
            cfg_clamp = TAG_W'(8);
        end
        else if (cfg_b > TAG_W'(LIMIT_BYTES))
        begin
            cfg_clamp = TAG_W'(LIMIT_BYTES);
        end
        else
        begin
            cfg_clamp = cfg_b;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = cfg_hit ? {{(PDATA_W - TAG_W){1'b0}}, end_reg, 2'b00} : '0;

    assign req_ready      = (state_reg == S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign payload_offset = poff_reg;

    always_comb
    begin
        state_next      = state_reg;
        end_next        = end_reg;
        clr_next        = clr_reg;
        h_next          = h_reg;
        nxt_next        = nxt_reg;
        size_next       = size_reg;
        avail_next      = avail_reg;
        split_next      = split_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;
        poff_next       = poff_reg;
        wr.en           = 1'b0;
        wr.addr         = h_reg;
        wr.data         = '0;
        raddr           = h_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.addr = clr_reg;
                if ((clr_reg == '0) || (clr_reg == end_ext - IDX_W'(1)))
                begin
                    wr.data = make_tag({end_reg - END_W'(2), 2'b00}, 1'b0);
                end
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == end_ext - IDX_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_status_next = STATUS_OK;
                    res_off_next    = '0;
                    if (func == FUNC_ALLOC)
                    begin
                        size_next  = ({1'b0, req_bytes} + TAG_W'(3)) & TAG_W'(13'h1FFC);
                        h_next     = '0;
                        state_next = S_A_RD;
                    end
                    else if ((fw == '0) || (fh >= end_ext))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        h_next     = fh;
                        raddr      = fh;
                        state_next = S_F_HDR;
                    end
                end
            end
            S_A_RD:
            begin
                if (h_reg >= end_ext)
                begin
                    res_status_next = STATUS_FULL;
                    res_off_next    = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    raddr      = h_reg;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (t_step > end_ext)
                begin
                    res_status_next = STATUS_FULL;
                    res_off_next    = '0;
                    state_next      = S_RESP;
                end
                else if (t_free && (t_size >= size_reg))
                begin
                    avail_next      = t_size;
                    split_next      = (size_reg + TAG_W'(8)) <= t_size;
                    wr.en           = 1'b1;
                    wr.addr         = h_reg;
                    wr.data         = ((size_reg + TAG_W'(8)) <= t_size)
                                      ? make_tag(size_reg, 1'b1) : make_tag(t_size, 1'b1);
                    res_status_next = STATUS_OK;
                    res_off_next    = {h_plus1[9:0], 2'b00};
                    state_next      = S_A_W1;
                end
                else
                begin
                    h_next     = t_step;
                    state_next = S_A_RD;
                end
            end
            S_A_W1:
            begin
                wr.en = 1'b1;
                if (split_reg)
                begin
                    wr.addr    = h_plus1 + q_size;
                    wr.data    = make_tag(size_reg, 1'b1);
                    state_next = S_A_W2;
                end
                else
                begin
                    wr.addr    = h_plus1 + q_avail;
                    wr.data    = make_tag(avail_reg, 1'b1);
                    state_next = S_RESP;
                end
            end
            S_A_W2:
            begin
                wr.en      = 1'b1;
                wr.addr    = h_reg + IDX_W'(2) + q_size;
                wr.data    = make_tag(rem_size, 1'b0);
                state_next = S_A_W3;
            end
            S_A_W3:
            begin
                wr.en      = 1'b1;
                wr.addr    = h_plus1 + q_avail;
                wr.data    = make_tag(rem_size, 1'b0);
                state_next = S_RESP;
            end
            S_F_HDR:
            begin
                size_next = t_size;
                nxt_next  = t_step;
                if (h_reg != '0)
                begin
                    raddr      = h_reg - IDX_W'(1);
                    state_next = S_F_PRV;
                end
                else
                begin
                    state_next = S_F_NRD;
                end
            end
            S_F_PRV:
            begin
                if (t_free && (({1'b0, rdata[TAG_W-1:2]} + IDX_W'(2)) <= h_reg))
                begin
                    size_next = size_reg + t_size + TAG_W'(8);
                    h_next    = h_reg - IDX_W'(2) - {1'b0, rdata[TAG_W-1:2]};
                end
                state_next = S_F_NRD;
            end
            S_F_NRD:
            begin
                if (nxt_reg < end_ext)
                begin
                    raddr      = nxt_reg;
                    state_next = S_F_NXT;
                end
                else
                begin
                    state_next = S_F_WH;
                end
            end
            S_F_NXT:
            begin
                if (t_free)
                begin
                    size_next = size_reg + t_size + TAG_W'(8);
                end
                state_next = S_F_WH;
            end
            S_F_WH:
            begin
                wr.en      = 1'b1;
                wr.addr    = h_reg;
                wr.data    = make_tag(size_reg, 1'b0);
                state_next = S_F_WF;
            end
            S_F_WF:
            begin
                wr.en      = 1'b1;
                wr.addr    = h_plus1 + q_size;
                wr.data    = make_tag(size_reg, 1'b0);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    poff_next      = res_off_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (cfg_wr)
        begin
            end_next   = cfg_clamp[TAG_W-1:2];
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            end_reg       <= END_W'(LIMIT_WORDS);
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg          <= h_next;
        nxt_reg        <= nxt_next;
        size_reg       <= size_next;
        avail_reg      <= avail_next;
        split_reg      <= split_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        status_reg     <= status_next;
        poff_reg       <= poff_next;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the boundary-tag first-fit allocator core
// Drives allocate and free transactions over valid/ready with random gaps and
// response back-pressure, re-forms the heap over APB between phases, and
// checks every response against a tag-level model of the implicit block list.
// ----------------------------------------------------------------------------
module tb_top;
    import bt_ffa_pkg::*;

    localparam int          HEAP_WORDS  = 1024;
    localparam int unsigned SIZE_MASK   = 32'h1FFC;
    localparam int unsigned TAG_BYTES   = 8;
    localparam int          CYCLE_LIMIT = 8000000;
    localparam int          PHASE_ITEMS = 295;
    localparam logic [PADDR_W-1:0] HEAP_ADDR = {REG_HEAP_BYTES, 2'b00};

    typedef struct packed {
        logic        status;
        logic [11:0] offset;
    } heap_rsp_t;

    class alloc_scoreboard;
        logic [TAG_W-1:0] tag_mem [HEAP_WORDS];
        int unsigned      heap_len;
        int unsigned      end_word;
        heap_rsp_t        expected_rsp[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            form_heap(4096);
        endfunction

        function void report(string msg);
            if (mismatches < 100)
                $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endfunction

        function int unsigned tag_at(int unsigned i);
            if (i < end_word && i < HEAP_WORDS)
                return 32'(tag_mem[i]);
            return 0;
        endfunction

        function void tag_put(int unsigned i, int unsigned v);
            if (i < end_word && i < HEAP_WORDS)
                tag_mem[i] = TAG_W'(v & 32'h1FFF);
        endfunction

        function void put_block(int unsigned h, int unsigned size, int unsigned alloc);
            int unsigned sz;
            int unsigned t;
            sz = size & SIZE_MASK;
            t  = sz | (alloc & 1);
            tag_put(h, t);
            tag_put(h + 1 + sz / 4, t);
        endfunction

        function void form_heap(int unsigned bytes);
            int unsigned limit;
            limit = 4 * HEAP_WORDS;
            if (limit > 4096)
                limit = 4096;
            bytes = bytes & ~32'd3;
            if (bytes < 8)
                bytes = 8;
            if (bytes > limit)
                bytes = limit;
            heap_len = bytes;
            end_word = bytes / 4;
            for (int i = 0; i < HEAP_WORDS; i++)
                tag_mem[i] = '0;
            put_block(0, bytes - TAG_BYTES, 0);
        endfunction

        function void configure(logic [31:0] value);
            form_heap(value & 32'h1FFF);
        endfunction

        function heap_rsp_t first_fit_alloc(int unsigned req);
            heap_rsp_t   r;
            int unsigned size;
            int unsigned h;
            int unsigned t;
            int unsigned avail;
            int unsigned nxt;
            size     = (req + 3) & ~32'd3;
            h        = 0;
            r.status = STATUS_FULL;
            r.offset = '0;
            while (h < end_word)
            begin
                t     = tag_at(h);
                avail = t & SIZE_MASK;
                nxt   = h + 2 + avail / 4;
                if (nxt > end_word)
                    break;
                if ((t & 1) == 0 && avail >= size)
                begin
                    if (size + TAG_BYTES <= avail)
                    begin
                        put_block(h, size, 1);
                        put_block(h + 2 + size / 4, avail - size - TAG_BYTES, 0);
                    end
                    else
                    begin
                        put_block(h, avail, 1);
                    end
                    r.status = STATUS_OK;
                    r.offset = 12'(((h + 1) * 4) & 32'hFFF);
                    return r;
                end
                h = nxt;
            end
            return r;
        endfunction

        function void release_block(int unsigned off);
            int unsigned w;
            int unsigned h;
            int unsigned size;
            int unsigned nxt;
            int unsigned pf;
            int unsigned ps;
            int unsigned nt;
            w = off >> 2;
            if (w < 1)
                return;
            h = w - 1;
            if (h >= end_word)
                return;
            size = tag_at(h) & SIZE_MASK;
            nxt  = h + 2 + size / 4;
            if (h != 0)
            begin
                pf = tag_at(h - 1);
                ps = pf & SIZE_MASK;
                if ((pf & 1) == 0 && ps / 4 + 2 <= h)
                begin
                    size = size + ps + TAG_BYTES;
                    h    = h - 2 - ps / 4;
                end
            end
            if (nxt < end_word)
            begin
                nt = tag_at(nxt);
                if ((nt & 1) == 0)
                    size = size + (nt & SIZE_MASK) + TAG_BYTES;
            end
            put_block(h, size, 0);
        endfunction

        function heap_rsp_t note_request(logic f, logic [11:0] rb, logic [11:0] bo);
            heap_rsp_t r;
            if (f == FUNC_ALLOC)
            begin
                r = first_fit_alloc(32'(rb));
            end
            else
            begin
                release_block(32'(bo));
                r.status = STATUS_OK;
                r.offset = '0;
            end
            expected_rsp.push_back(r);
            return r;
        endfunction

        function void check_response(logic st, logic [11:0] off);
            heap_rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                report($sformatf("response with nothing outstanding: status %0b offset %0d",
                                 st, off));
                return;
            end
            e = expected_rsp.pop_front();
            if (st !== e.status)
                report($sformatf("status %0b, expected %0b", st, e.status));
            if (off !== e.offset)
                report($sformatf("payload_offset %0d, expected %0d", off, e.offset));
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid    = 1'b0;
    logic                req_ready;
    logic                func         = FUNC_ALLOC;
    logic [11:0]         req_bytes    = '0;
    logic [11:0]         block_offset = '0;
    logic                rsp_valid;
    logic                rsp_ready    = 1'b0;
    logic                status;
    logic [11:0]         payload_offset;

    bit                  calm         = 1'b0;
    int                  cycle_count  = 0;
    alloc_scoreboard     sb;

    boundary_tag_first_fit_allocator_core #(
        .HEAP_WORDS(HEAP_WORDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .func           (func),
        .req_bytes      (req_bytes),
        .block_offset   (block_offset),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .payload_offset (payload_offset)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(99) >= 10);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(status, payload_offset);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic f, input logic [11:0] rb, input logic [11:0] bo,
                             output heap_rsp_t r);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 10)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        func         <= f;
        req_bytes    <= rb;
        block_offset <= bo;
        do @(posedge clk); while (!req_ready);
        r = sb.note_request(f, rb, bo);
    endtask

    task automatic request_alloc(input logic [11:0] rb, output heap_rsp_t r);
        send_item(FUNC_ALLOC, rb, 12'($urandom()), r);
    endtask

    task automatic request_free(input logic [11:0] bo);
        heap_rsp_t r;
        send_item(FUNC_FREE, 12'($urandom()), bo, r);
    endtask

    // hold off new transactions until every response is back
    task automatic wait_all_responses();
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEAP_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.configure(data);
    endtask

    initial
    begin
        heap_rsp_t   r;
        logic [11:0] a0;
        logic [11:0] a1;
        logic [11:0] a2;
        logic [11:0] a3;
        logic [11:0] live[$];
        logic [11:0] rb;
        logic [11:0] bo;
        logic [31:0] heap_cfg[6];
        int unsigned pick;
        int unsigned sel;
        int unsigned small_max;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        request_alloc(12'd0, r);
        a0 = r.offset;
        request_alloc(12'd1, r);
        a1 = r.offset;
        request_alloc(12'd4, r);
        a2 = r.offset;
        request_alloc(12'd100, r);
        a3 = r.offset;
        request_free(a1);
        request_free(a0);
        request_free(a3 | 12'd1);
        request_free(a2);
        request_alloc(12'd4088, r);
        request_alloc(12'd0, r);
        request_free(12'd4);
        request_alloc(12'hFFF, r);
        request_alloc(12'd4080, r);
        request_free(12'd4);
        request_alloc(12'd4084, r);
        request_free(12'd4);
        request_free(12'd0);
        request_free(12'd3);
        request_free(12'hFFF);
        request_alloc(12'd16, r);
        wait_all_responses();

        apb_write(32'd5);
        request_alloc(12'd0, r);
        request_alloc(12'd0, r);
        request_free(12'd4);
        request_free(12'hFFC);
        request_alloc(12'd8, r);
        wait_all_responses();

        heap_cfg[0] = ($urandom() & ~32'h1FFF) | 32'h1FFF;
        heap_cfg[1] = 32'd12;
        heap_cfg[2] = 32'd256;
        heap_cfg[3] = $urandom_range(8, 4096);
        heap_cfg[4] = 32'd4096;
        heap_cfg[5] = 32'd2050;

        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(heap_cfg[ph]);
            live.delete();
            calm = (ph == 4);
            small_max = (sb.heap_len > 512) ? 64 : sb.heap_len / 4;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_all_responses();
                sel = $urandom_range(99);
                if (sel < 94 && (sel < 50 || live.size() == 0))
                begin
                    if ($urandom_range(7) == 0)
                        rb = 12'($urandom_range(0, sb.heap_len - TAG_BYTES));
                    else
                        rb = 12'($urandom_range(0, small_max));
                    request_alloc(rb, r);
                    if (r.status == STATUS_OK)
                        live.push_back(r.offset);
                end
                else if (sel < 94)
                begin
                    pick = $urandom_range(0, live.size() - 1);
                    bo   = live[pick];
                    live.delete(pick);
                    if ($urandom_range(3) == 0)
                        bo = bo | 12'($urandom_range(1, 3));
                    request_free(bo);
                end
                else if (sel < 97)
                begin
                    request_alloc(12'($urandom()), r);
                    if (r.status == STATUS_OK)
                        live.push_back(r.offset);
                end
                else
                begin
                    request_free(12'($urandom()));
                end
            end
            wait_all_responses();
        end

        calm = 1'b0;
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
